// ===== sv/serial_command_frame_receiver_assert.svh =====
// Assertion helpers for the frame receiver.
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be true out of reset.
`define SCF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/scf_pkg.sv =====
package scf_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx_byte;
        logic [15:0] current_speed;
        logic [7:0]  current_direction;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_data;
        logic        tx_last;
        logic [1:0]  setting_select;
        logic [15:0] setting_value;
    } t_out;

    // One finished frame: an optional setting update, then four bytes to send.
    typedef struct packed {
        logic            upd;
        logic [1:0]      sel;
        logic [15:0]     val;
        logic [3:0][7:0] bytes;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [7:0] SVC_CRANK_PROFILE = 8'd1;
    localparam logic [7:0] SVC_CAM_PROFILE   = 8'd2;
    localparam logic [7:0] SVC_SET_SPEED     = 8'd3;
    localparam logic [7:0] SVC_SET_DIRECTION = 8'd4;
    localparam logic [7:0] SVC_GET_SPEED     = 8'd5;
    localparam logic [7:0] SVC_SET_STOP      = 8'd6;

    localparam logic [7:0] ACK_MARK   = 8'd81;
    localparam logic [7:0] SPEED_MARK = 8'd82;

    localparam logic       REQ_BYTE = 1'b0;
    localparam logic       REQ_TICK = 1'b1;

    localparam logic       KIND_TX     = 1'b0;
    localparam logic       KIND_UPDATE = 1'b1;

    localparam logic [1:0] SEL_SPEED = 2'd0;
    localparam logic [1:0] SEL_STOP  = 2'd1;
    localparam logic [1:0] SEL_DIR   = 2'd2;

    localparam int         CFG_IDX_W  = 3;
    localparam int         CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NACK    = 3'd4;

    function automatic logic valid_service(input logic [7:0] s);
        return s == SVC_CRANK_PROFILE || s == SVC_CAM_PROFILE || s == SVC_SET_SPEED ||
               s == SVC_SET_DIRECTION || s == SVC_GET_SPEED || s == SVC_SET_STOP;
    endfunction

endpackage

// ===== sv/scf_front.sv =====
module scf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  scf_pkg::t_in                     i_in,
    input  scf_pkg::t_qstat                  i_qstat,
    input  logic                             i_cfg_we,
    input  logic [scf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_job_push,
    output scf_pkg::t_job                    o_job
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_SERVICE,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_pcount, n_pcount;
    logic [7:0]  r_flen, n_flen;
    logic [7:0]  r_svc, n_svc;
    logic [7:0]  r_plow, n_plow;
    logic [7:0]  r_phigh, n_phigh;
    logic [31:0] r_tick, n_tick;

    logic [7:0]  r_header;
    logic [31:0] r_timeout;
    logic [15:0] r_speed_lim;
    logic [7:0]  r_ack;
    logic [7:0]  r_nack;

    logic        w_accept;
    logic [31:0] w_tick_inc;
    logic [7:0]  w_b;
    logic [15:0] w_val;

    assign w_accept = i_push && !i_qstat.full;
    assign w_b      = i_in.rx_byte;
    assign w_val    = {r_phigh, r_plow};

    always_comb begin
        n_phase    = r_phase;
        n_check    = r_check;
        n_pcount   = r_pcount;
        n_flen     = r_flen;
        n_svc      = r_svc;
        n_plow     = r_plow;
        n_phigh    = r_phigh;
        n_tick     = r_tick;
        w_tick_inc = (r_tick == '1) ? r_tick : r_tick + 32'd1;
        o_job_push = 1'b0;
        o_job      = '0;
        o_job.bytes[0] = scf_pkg::ACK_MARK;
        o_job.bytes[1] = r_ack;
        o_job.bytes[2] = r_svc;
        o_job.bytes[3] = 8'd0;

        if (w_accept) begin
            if (i_in.req_type == scf_pkg::REQ_TICK) begin
                n_tick = w_tick_inc;
                if (w_tick_inc >= r_timeout) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                end
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        if (w_b == r_header) begin
                            n_phase  = PH_HEADER;
                            n_check  = w_b;
                            n_pcount = '0;
                        end
                    end
                    PH_HEADER: begin
                        if (scf_pkg::valid_service(w_b)) begin
                            n_svc   = w_b;
                            n_check = r_check | w_b;
                            n_phase = PH_SERVICE;
                        end
                    end
                    PH_SERVICE: begin
                        n_flen   = w_b;
                        n_check  = r_check | w_b;
                        n_pcount = '0;
                        n_phase  = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        if (r_pcount < r_flen) begin
                            if (r_pcount == 8'd0) begin
                                n_plow = w_b;
                            end else if (r_pcount == 8'd1) begin
                                n_phigh = w_b;
                            end
                            n_check  = r_check | w_b;
                            n_pcount = r_pcount + 8'd1;
                        end else begin
                            // The check byte closes the frame, good or bad.
                            n_phase    = PH_WAIT;
                            n_pcount   = '0;
                            o_job_push = 1'b1;
                            if (w_b != r_check) begin
                                o_job.bytes[1] = r_nack;
                            end else begin
                                n_tick = '0;
                                case (r_svc)
                                    scf_pkg::SVC_GET_SPEED: begin
                                        o_job.bytes[0] = scf_pkg::SPEED_MARK;
                                        o_job.bytes[1] = i_in.current_speed[7:0];
                                        o_job.bytes[2] = i_in.current_speed[15:8];
                                        o_job.bytes[3] = i_in.current_direction;
                                    end
                                    scf_pkg::SVC_SET_SPEED: begin
                                        if (w_val <= r_speed_lim) begin
                                            o_job.upd = 1'b1;
                                            o_job.sel = scf_pkg::SEL_SPEED;
                                            o_job.val = w_val;
                                        end else begin
                                            o_job.bytes[1] = r_nack;
                                        end
                                    end
                                    scf_pkg::SVC_SET_DIRECTION: begin
                                        o_job.upd = 1'b1;
                                        o_job.sel = scf_pkg::SEL_DIR;
                                        o_job.val = w_val;
                                    end
                                    scf_pkg::SVC_SET_STOP: begin
                                        o_job.upd = 1'b1;
                                        o_job.sel = scf_pkg::SEL_STOP;
                                        o_job.val = w_val;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_check     <= '0;
            r_pcount    <= '0;
            r_flen      <= '0;
            r_svc       <= '0;
            r_plow      <= '0;
            r_phigh     <= '0;
            r_tick      <= '0;
            r_header    <= 8'd0;
            r_timeout   <= 32'd1000;
            r_speed_lim <= 16'hFFFF;
            r_ack       <= 8'd1;
            r_nack      <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_check  <= n_check;
            r_pcount <= n_pcount;
            r_flen   <= n_flen;
            r_svc    <= n_svc;
            r_plow   <= n_plow;
            r_phigh  <= n_phigh;
            r_tick   <= n_tick;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    scf_pkg::CFG_HEADER:  r_header    <= i_cfg_data[7:0];
                    scf_pkg::CFG_TIMEOUT: r_timeout   <= i_cfg_data[31:0];
                    scf_pkg::CFG_SPEED:   r_speed_lim <= i_cfg_data[15:0];
                    scf_pkg::CFG_ACK:     r_ack       <= i_cfg_data[7:0];
                    scf_pkg::CFG_NACK:    r_nack      <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/scf_queue.sv =====
module scf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scf_pkg::t_job   i_data,
    input  logic            i_pop,
    output scf_pkg::t_job   o_data,
    output scf_pkg::t_qstat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    scf_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== sv/scf_back.sv =====
module scf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scf_pkg::t_job   i_job,
    input  scf_pkg::t_qstat i_qstat,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output scf_pkg::t_out   o_out
);

    scf_pkg::t_job r_job;
    logic          r_busy;
    logic [2:0]    r_step;
    scf_pkg::t_out r_out;
    logic          r_out_valid;

    logic          w_slot_free;
    logic          w_emit;
    logic          w_last;
    logic [1:0]    w_byte_idx;
    scf_pkg::t_out w_word;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_emit      = r_busy && w_slot_free;
    assign o_job_pop   = !r_busy && !i_qstat.empty;
    assign w_last      = (r_step == 3'd4);
    assign w_byte_idx  = 2'(r_step - 3'd1);
    assign o_empty     = !r_out_valid;
    assign o_out       = r_out;

    // Step zero is the setting update; steps one to four are the sent bytes.
    always_comb begin
        w_word = '0;
        if (r_step == 3'd0) begin
            w_word.kind           = scf_pkg::KIND_UPDATE;
            w_word.setting_select = r_job.sel;
            w_word.setting_value  = r_job.val;
        end else begin
            w_word.kind    = scf_pkg::KIND_TX;
            w_word.tx_data = r_job.bytes[w_byte_idx];
            w_word.tx_last = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_word;
        end
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_step      <= r_step + 3'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_job_pop) begin
                r_busy <= 1'b1;
                r_step <= i_job.upd ? 3'd0 : 3'd1;
            end
        end
    end

endmodule

// ===== sv/serial_command_frame_receiver.sv =====
// Command frame receiver. Push takes one word per cycle while full is low: a received
// byte or a poll tick. Bytes are parsed into frames (header, service, length, payload,
// check byte) by the front end in the cycle they arrive; a closed frame becomes a job
// in a JOB_DEPTH entry queue, and the back end loads each job into a register and turns
// it into four or five result words, one per cycle while the result side keeps popping,
// taking no new job until the last word is out; full rises only while the job queue is
// full. Configuration registers (0 header, 1 timeout, 2 speed limit, 3 ack code, 4 nack
// code) are written through the write port, one per cycle; other indexes are ignored.
// The user must write them only while the block is idle; the block does not enforce it.
`include "serial_command_frame_receiver_assert.svh"

module serial_command_frame_receiver #(
    parameter int JOB_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  scf_pkg::t_in                   i_in,
    output logic                           empty,
    input  logic                           pop,
    output scf_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [scf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    scf_pkg::t_qstat w_qstat;
    scf_pkg::t_job   w_job_in;
    scf_pkg::t_job   w_job_out;
    logic            w_job_push;
    logic            w_job_pop;
    logic            w_byte_acc;

    assign full       = w_qstat.full;
    assign w_byte_acc = push && !full && (i_in.req_type == scf_pkg::REQ_BYTE);

    scf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in       (i_in),
        .i_qstat    (w_qstat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    scf_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_stat  (w_qstat)
    );

    scf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_job_out),
        .i_qstat   (w_qstat),
        .o_job_pop (w_job_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

    `SCF_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_job_push && w_qstat.full, "queue overflow")
    `SCF_ASSERT_IMP(a_pop_needs_job, i_clk, i_rst_n, w_job_pop, !w_qstat.empty, "queue underflow")
    `SCF_ASSERT_IMP(a_job_from_byte, i_clk, i_rst_n, w_job_push, w_byte_acc, "job without a byte")

endmodule

// ===== tb/scf_reply_checker.sv =====
`timescale 1ns / 100ps

module scf_reply_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  scf_pkg::t_in                   i_item,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  scf_pkg::t_out                  i_reply,
    input  logic                           i_cfg_we,
    input  logic [scf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_GOT_HEADER,
        RX_GOT_SERVICE,
        RX_PAYLOAD
    } t_rx_phase;

    // Register copies.
    logic [7:0]  cfg_header;
    logic [31:0] cfg_timeout;
    logic [15:0] cfg_speed_max;
    logic [7:0]  cfg_ack;
    logic [7:0]  cfg_nack;

    // Frame parser state.
    t_rx_phase   rx_phase;
    logic [7:0]  chk_or;
    logic [7:0]  pay_cnt;
    logic [7:0]  pay_len;
    logic [7:0]  svc;
    logic [7:0]  pay_lo;
    logic [7:0]  pay_hi;
    logic [31:0] tick_cnt;

    scf_pkg::t_out expected_replies[$];
    int            err_count = 0;

    function automatic void add_word(input logic k, input logic [7:0] d,
                                     input logic [1:0] s, input logic [15:0] v);
        scf_pkg::t_out r;
        r.kind           = k;
        r.tx_data        = d;
        r.tx_last        = 1'b0;
        r.setting_select = s;
        r.setting_value  = v;
        expected_replies.push_back(r);
    endfunction

    function automatic void add_ack(input logic [7:0] status);
        add_word(scf_pkg::KIND_TX, scf_pkg::ACK_MARK, '0, '0);
        add_word(scf_pkg::KIND_TX, status, '0, '0);
        add_word(scf_pkg::KIND_TX, svc, '0, '0);
        add_word(scf_pkg::KIND_TX, 8'h00, '0, '0);
    endfunction

    task automatic predict_replies(input scf_pkg::t_in w);
        logic [7:0]    b;
        logic [15:0]   val;
        int            base;
        scf_pkg::t_out tail;
        b    = w.rx_byte;
        base = expected_replies.size();
        if (w.req_type == scf_pkg::REQ_TICK) begin
            if (tick_cnt != '1) tick_cnt++;
            if (tick_cnt >= cfg_timeout) begin
                rx_phase = RX_IDLE;
                tick_cnt = '0;
            end
        end else begin
            case (rx_phase)
                RX_IDLE: begin
                    if (b == cfg_header) begin
                        rx_phase = RX_GOT_HEADER;
                        chk_or   = b;
                        pay_cnt  = '0;
                    end
                end
                RX_GOT_HEADER: begin
                    // The valid codes form one contiguous range.
                    if (b >= scf_pkg::SVC_CRANK_PROFILE && b <= scf_pkg::SVC_SET_STOP) begin
                        svc      = b;
                        chk_or   = chk_or | b;
                        rx_phase = RX_GOT_SERVICE;
                    end
                end
                RX_GOT_SERVICE: begin
                    pay_len  = b;
                    chk_or   = chk_or | b;
                    pay_cnt  = '0;
                    rx_phase = RX_PAYLOAD;
                end
                default: begin
                    if (pay_cnt < pay_len) begin
                        if (pay_cnt == 8'd0) pay_lo = b;
                        else if (pay_cnt == 8'd1) pay_hi = b;
                        chk_or  = chk_or | b;
                        pay_cnt = pay_cnt + 8'd1;
                    end else begin
                        val      = {pay_hi, pay_lo};
                        rx_phase = RX_IDLE;
                        pay_cnt  = '0;
                        if (b != chk_or) begin
                            add_ack(cfg_nack);
                        end else begin
                            tick_cnt = '0;
                            case (svc)
                                scf_pkg::SVC_GET_SPEED: begin
                                    add_word(scf_pkg::KIND_TX, scf_pkg::SPEED_MARK, '0, '0);
                                    add_word(scf_pkg::KIND_TX, w.current_speed[7:0], '0, '0);
                                    add_word(scf_pkg::KIND_TX, w.current_speed[15:8], '0, '0);
                                    add_word(scf_pkg::KIND_TX, w.current_direction, '0, '0);
                                end
                                scf_pkg::SVC_SET_SPEED: begin
                                    if (val <= cfg_speed_max) begin
                                        add_word(scf_pkg::KIND_UPDATE, 8'h00,
                                                 scf_pkg::SEL_SPEED, val);
                                        add_ack(cfg_ack);
                                    end else begin
                                        add_ack(cfg_nack);
                                    end
                                end
                                scf_pkg::SVC_SET_DIRECTION: begin
                                    add_word(scf_pkg::KIND_UPDATE, 8'h00, scf_pkg::SEL_DIR, val);
                                    add_ack(cfg_ack);
                                end
                                scf_pkg::SVC_SET_STOP: begin
                                    add_word(scf_pkg::KIND_UPDATE, 8'h00, scf_pkg::SEL_STOP, val);
                                    add_ack(cfg_ack);
                                end
                                default: add_ack(cfg_ack);
                            endcase
                        end
                    end
                end
            endcase
        end
        if (expected_replies.size() > base) begin
            tail         = expected_replies.pop_back();
            tail.tx_last = 1'b1;
            expected_replies.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        scf_pkg::t_out want;
        if (!i_rst_n) begin
            cfg_header    = 8'd0;
            cfg_timeout   = 32'd1000;
            cfg_speed_max = 16'hFFFF;
            cfg_ack       = 8'd1;
            cfg_nack      = 8'd0;
            rx_phase      = RX_IDLE;
            chk_or        = '0;
            pay_cnt       = '0;
            pay_len       = '0;
            svc           = '0;
            pay_lo        = '0;
            pay_hi        = '0;
            tick_cnt      = '0;
            expected_replies.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual %0h",
                             $time, i_reply);
                    err_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("kind", want.kind, i_reply.kind);
                    check_field("tx_data", want.tx_data, i_reply.tx_data);
                    check_field("tx_last", want.tx_last, i_reply.tx_last);
                    check_field("setting_select", want.setting_select,
                                i_reply.setting_select);
                    check_field("setting_value", want.setting_value,
                                i_reply.setting_value);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    scf_pkg::CFG_HEADER:  cfg_header    = i_cfg_data[7:0];
                    scf_pkg::CFG_TIMEOUT: cfg_timeout   = i_cfg_data;
                    scf_pkg::CFG_SPEED:   cfg_speed_max = i_cfg_data[15:0];
                    scf_pkg::CFG_ACK:     cfg_ack       = i_cfg_data[7:0];
                    scf_pkg::CFG_NACK:    cfg_nack      = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) predict_replies(i_item);
        end
        o_errors  <= err_count;
        o_pending <= expected_replies.size();
    end

endmodule

// ===== tb/tb_serial_command_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_serial_command_frame_receiver;

    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push    = 1'b0;
    logic                           pop     = 1'b0;
    logic                           full;
    logic                           empty;
    scf_pkg::t_in                   item    = '0;
    scf_pkg::t_out                  reply;
    logic                           cfg_we   = 1'b0;
    logic [scf_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [scf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             errors;
    int                             pending;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    bit          hold_done      = 1'b0;
    int          fed_items      = 0;
    logic [7:0]  hdr            = 8'd0;
    logic [15:0] speed_cap      = 16'hFFFF;

    logic [7:0] svc_codes [6] = '{scf_pkg::SVC_CRANK_PROFILE, scf_pkg::SVC_CAM_PROFILE,
                                  scf_pkg::SVC_SET_SPEED, scf_pkg::SVC_SET_DIRECTION,
                                  scf_pkg::SVC_GET_SPEED, scf_pkg::SVC_SET_STOP};

    serial_command_frame_receiver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (item),
        .empty      (empty),
        .pop        (pop),
        .o_out      (reply),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    scf_reply_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_item     (item),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_reply    (reply),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, or one long hold-off when asked for.
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [15:0] rand_speed();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input scf_pkg::t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        item <= w;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_noise(input logic [7:0] b);
        scf_pkg::t_in w;
        w.req_type          = scf_pkg::REQ_BYTE;
        w.rx_byte           = b;
        w.current_speed     = rand_speed();
        w.current_direction = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_noise(b);
        fed_items++;
    endtask

    task automatic send_tick();
        scf_pkg::t_in w;
        w.req_type          = scf_pkg::REQ_TICK;
        w.rx_byte           = 8'($urandom_range(0, 255));
        w.current_speed     = rand_speed();
        w.current_direction = 8'($urandom_range(0, 255));
        send_word(w);
        fed_items++;
    endtask

    task automatic send_frame(input logic [7:0] svc, input int len, input logic [7:0] lo,
                              input logic [7:0] hi, input bit good, input bit junk_svc,
                              input bit tick_late, input logic [15:0] spd,
                              input logic [7:0] dir);
        logic [7:0]   chk;
        logic [7:0]   b;
        scf_pkg::t_in w;
        chk = hdr | svc | 8'(len);
        send_rx(hdr);
        // An invalid code between header and service must be skipped over.
        if (junk_svc) send_noise($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(7, 255)));
        send_rx(svc);
        send_rx(8'(len));
        for (int i = 0; i < len; i++) begin
            b = (i == 0) ? lo : (i == 1) ? hi : 8'($urandom_range(0, 255));
            chk = chk | b;
            send_rx(b);
        end
        if (tick_late) send_tick();
        w.req_type          = scf_pkg::REQ_BYTE;
        w.rx_byte           = good ? chk : chk ^ 8'($urandom_range(1, 255));
        w.current_speed     = spd;
        w.current_direction = dir;
        send_word(w);
        fed_items++;
    endtask

    task automatic send_random_frame(input bit always_good);
        logic [7:0]  svc;
        logic [15:0] val;
        int          len;
        svc = svc_codes[$urandom_range(0, 5)];
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 20);
        val = 16'($urandom_range(0, 65535));
        // Land on either side of the speed limit now and then.
        if (svc == scf_pkg::SVC_SET_SPEED && $urandom_range(0, 2) == 0)
            val = speed_cap + 16'($urandom_range(0, 1));
        send_frame(svc, len, val[7:0], val[15:8],
                   always_good || ($urandom_range(99) < 85),
                   !always_good && ($urandom_range(99) < 10),
                   !always_good && ($urandom_range(99) < 10),
                   rand_speed(), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            send_random_frame(1'b0);
        end else if (r < 82) begin
            repeat ($urandom_range(1, 3)) send_noise(8'($urandom_range(0, 255)));
        end else if (r < 92) begin
            repeat ($urandom_range(1, 3)) send_tick();
        end else begin
            // A frame that breaks off early.
            send_rx(hdr);
            repeat ($urandom_range(0, 3)) send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic apply_settings(input logic [7:0] header, input logic [31:0] timeout,
                                  input logic [15:0] speed, input logic [7:0] ack,
                                  input logic [7:0] nack);
        logic [scf_pkg::CFG_IDX_W-1:0]  regs [5];
        logic [scf_pkg::CFG_DATA_W-1:0] vals [5];
        regs = '{scf_pkg::CFG_HEADER, scf_pkg::CFG_TIMEOUT, scf_pkg::CFG_SPEED,
                 scf_pkg::CFG_ACK, scf_pkg::CFG_NACK};
        vals = '{32'(header), timeout, 32'(speed), 32'(ack), 32'(nack)};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we    <= 1'b0;
        hdr       = header;
        speed_cap = speed;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int target, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        fed_items      = 0;
        while (fed_items < target) send_random_sequence();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks.
        apply_settings(8'hA5, 32'd4, 16'd1000, 8'hFF, 8'h00);
        send_noise(8'h00);
        send_frame(scf_pkg::SVC_SET_SPEED, 2, 8'hE9, 8'h03, 1'b1, 1'b1, 1'b0,
                   rand_speed(), 8'h5A);
        send_frame(scf_pkg::SVC_GET_SPEED, 0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0,
                   16'hFFFF, 8'hFF);
        send_frame(scf_pkg::SVC_CRANK_PROFILE, 0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                   16'h0000, 8'h00);
        send_frame(scf_pkg::SVC_SET_STOP, 1, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0,
                   rand_speed(), 8'h00);
        // Timeout in the middle of a frame; the next frame must parse from scratch.
        send_rx(hdr);
        send_rx(scf_pkg::SVC_CAM_PROFILE);
        repeat (4) send_tick();
        send_frame(scf_pkg::SVC_SET_DIRECTION, 0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0,
                   rand_speed(), 8'h00);
        drain();

        apply_settings(8'h00, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 8'hFF);
        run_phase(10, 0, 0);
        send_frame(svc_codes[$urandom_range(0, 5)], 16, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0,
                   rand_speed(), 8'($urandom_range(0, 255)));
        drain();

        apply_settings(8'hFF, 32'd1, 16'd0, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        run_phase(10, 52, 0);
        drain();

        apply_settings(8'($urandom_range(0, 255)), 32'($urandom_range(2, 8)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        run_phase(10, 0, 52);
        drain();

        apply_settings(8'($urandom_range(0, 255)), 32'($urandom_range(2, 40)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        run_phase(10, 34, 34);
        drain();

        // Back pressure: the result side holds off while good frames keep coming.
        apply_settings(8'($urandom_range(0, 255)), 32'd1000, 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        fed_items      = 0;
        while (fed_items < 24) send_random_frame(1'b1);
        drain();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
